// ===== rtl/bfm_pkg.sv =====
// shared types, constants and the crc-8 step for the bpsk frame modulator
// no dependencies; compiled first
package bfm_pkg;

    localparam int unsigned PAYLOAD_BYTES = 64;
    localparam int unsigned SYNC_BITS     = 32;
    localparam int unsigned SYNC_BYTES    = SYNC_BITS / 8;
    localparam int unsigned FRAME_BITS    = SYNC_BITS + 8 * PAYLOAD_BYTES;

    localparam int unsigned IDX_W  = (PAYLOAD_BYTES > 2) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int unsigned BIT_W  = $clog2(FRAME_BITS);
    localparam int unsigned ADDR_W = IDX_W + 1;
    localparam int unsigned RAM_DEPTH = 2 ** ADDR_W;

    localparam int unsigned SYNC_W     = 32;
    localparam int unsigned AMP_W      = 15;
    localparam int unsigned SPS_W      = 4;
    localparam int unsigned SMP_W      = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

    localparam logic [SYNC_W-1:0] SYNC_RST = 32'h1ACF_FC1D;
    localparam logic [AMP_W-1:0]  AMP_RST  = 15'd15000;
    localparam logic [SPS_W-1:0]  SPS_RST  = 4'd5;

    // last payload slot holds the crc
    localparam logic [IDX_W-1:0] CRC_POS  = IDX_W'(PAYLOAD_BYTES - 1);
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(FRAME_BITS - 1);
    localparam logic [BIT_W-1:0] SYNC_END = BIT_W'(SYNC_BITS);

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TICK = 1'b1
    } t_req_type;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC        = 2'd0,
        REG_AMPLITUDE   = 2'd1,
        REG_SAMPLES_SYM = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_ram_rd;

    // msb-first crc-8, no reflection, no final xor
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/bfm_ifs.sv =====
// valid/ready channel interfaces: input items, output samples, register writes
// depends on bfm_pkg
interface bfm_item_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [bfm_pkg::BYTE_W-1:0]   payload_byte;

    modport source (output valid, output req_type, output payload_byte, input ready);
    modport sink   (input valid, input req_type, input payload_byte, output ready);
endinterface

interface bfm_sample_if;
    logic                               valid;
    logic                               ready;
    logic signed [bfm_pkg::SMP_W-1:0]   i_sample;
    logic signed [bfm_pkg::SMP_W-1:0]   q_sample;
    logic                               frame_start;
    logic                               frame_valid;

    modport source (output valid, output i_sample, output q_sample, output frame_start,
                    output frame_valid, input ready);
    modport sink   (input valid, input i_sample, input q_sample, input frame_start,
                    input frame_valid, output ready);
endinterface

interface bfm_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bfm_pkg::CFG_IDX_W-1:0]    index;
    logic [bfm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bfm_frame_ram.sv =====
// two-bank payload byte store, one write and one registered read per cycle
// depends on bfm_pkg
module bfm_frame_ram (
    input  logic                       i_clk,
    input  bfm_pkg::t_ram_wr           i_wr,
    input  bfm_pkg::t_ram_rd           i_rd,
    output logic [bfm_pkg::BYTE_W-1:0] o_rd_data
);

    logic [bfm_pkg::BYTE_W-1:0] mem [bfm_pkg::RAM_DEPTH];
    logic [bfm_pkg::BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/bpsk_frame_modulator.sv =====
// bpsk frame modulator: sync word + payload + crc-8, double-buffered frame swap
// a tick transfer reaches the output through the read stage and output registers
// throughput: one item per cycle while the sample output is not stalled
// synchronous active-low reset clears counters, flags and configuration to defaults;
// frame ram contents are undefined after reset and never read before a full frame
module bpsk_frame_modulator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bfm_item_if.sink            i_item,
    bfm_cfg_if.sink             i_cfg,
    bfm_sample_if.source        o_sample
);

    // configuration
    logic [bfm_pkg::SYNC_W-1:0] r_sync;
    logic [bfm_pkg::AMP_W-1:0]  r_amp;
    logic [bfm_pkg::SPS_W-1:0]  r_sps;

    // frame state; bank bits say which ram bank holds each active/shadow entry
    logic [bfm_pkg::PAYLOAD_BYTES-1:0] r_act_bank, r_sh_bank;
    logic [bfm_pkg::BYTE_W-1:0]  r_act_crc, r_sh_crc;
    logic [bfm_pkg::IDX_W-1:0]   r_wp;
    logic [bfm_pkg::BYTE_W-1:0]  r_crc;
    logic                        r_swap_pend;
    logic                        r_act_valid;
    logic [bfm_pkg::BIT_W-1:0]   r_bit_pos;
    logic [bfm_pkg::SPS_W-1:0]   r_smp_cnt;

    // read stage
    logic                        r_s1_v;
    logic                        r_s1_av, r_s1_start, r_s1_sync, r_s1_sync_bit, r_s1_crc;
    logic [bfm_pkg::BYTE_W-1:0]  r_s1_crc_byte;
    logic [2:0]                  r_s1_bsel;
    logic [bfm_pkg::AMP_W-1:0]   r_s1_amp;

    // output register
    logic                             r_out_v;
    logic signed [bfm_pkg::SMP_W-1:0] r_out_i;
    logic                             r_out_fs, r_out_fv;

    logic                        s1_adv, in_acc, load_acc, tick_acc;
    logic                        start, swap, av_now;
    logic [bfm_pkg::PAYLOAD_BYTES-1:0] act_bank_now;
    logic [bfm_pkg::BYTE_W-1:0]  act_crc_now;
    logic [bfm_pkg::BIT_W-4:0]   byte_sel;
    logic [bfm_pkg::IDX_W-1:0]   byte_idx;
    logic                        is_sync, is_crc;
    logic [bfm_pkg::SPS_W-1:0]   sps_eff;
    logic [bfm_pkg::SPS_W:0]     n_smp_cnt;
    logic                        bit_done;
    logic [bfm_pkg::BYTE_W-1:0]  n_crc;
    logic [bfm_pkg::IDX_W:0]     n_wp;
    logic                        frame_done;
    logic [bfm_pkg::BYTE_W-1:0]  rd_data;
    logic                        s1_bit;
    logic signed [bfm_pkg::SMP_W-1:0] s1_pos, s1_smp;
    bfm_pkg::t_ram_wr            ram_wr;
    bfm_pkg::t_ram_rd            ram_rd;

    // handshakes
    assign s1_adv   = !r_out_v || o_sample.ready;
    assign i_item.ready = !r_s1_v || s1_adv;
    assign in_acc   = i_item.valid && i_item.ready;
    assign load_acc = in_acc && (i_item.req_type == bfm_pkg::REQ_LOAD);
    assign tick_acc = in_acc && (i_item.req_type == bfm_pkg::REQ_TICK);
    assign i_cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= bfm_pkg::SYNC_RST;
            r_amp  <= bfm_pkg::AMP_RST;
            r_sps  <= bfm_pkg::SPS_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (bfm_pkg::t_cfg_reg'(i_cfg.index))
                bfm_pkg::REG_SYNC:        r_sync <= i_cfg.data[bfm_pkg::SYNC_W-1:0];
                bfm_pkg::REG_AMPLITUDE:   r_amp  <= i_cfg.data[bfm_pkg::AMP_W-1:0];
                bfm_pkg::REG_SAMPLES_SYM: r_sps  <= i_cfg.data[bfm_pkg::SPS_W-1:0];
                default: ;
            endcase
        end
    end

    // tick side: frame boundary, swap and position decode
    always_comb begin
        start        = (r_bit_pos == '0) && (r_smp_cnt == '0);
        swap         = start && r_swap_pend;
        av_now       = r_act_valid || swap;
        act_bank_now = swap ? r_sh_bank : r_act_bank;
        act_crc_now  = swap ? r_sh_crc : r_act_crc;
        is_sync      = r_bit_pos < bfm_pkg::SYNC_END;
        byte_sel     = r_bit_pos[bfm_pkg::BIT_W-1:3] - (bfm_pkg::BIT_W-3)'(bfm_pkg::SYNC_BYTES);
        byte_idx     = byte_sel[bfm_pkg::IDX_W-1:0];
        is_crc       = !is_sync && (byte_idx == bfm_pkg::CRC_POS);
        sps_eff      = (r_sps == '0) ? bfm_pkg::SPS_W'(1) : r_sps;
        n_smp_cnt    = {1'b0, r_smp_cnt} + (bfm_pkg::SPS_W+1)'(1);
        bit_done     = n_smp_cnt >= {1'b0, sps_eff};
    end

    // load side: crc step and write position
    always_comb begin
        n_crc      = bfm_pkg::crc8_byte(r_crc, i_item.payload_byte);
        n_wp       = {1'b0, r_wp} + (bfm_pkg::IDX_W+1)'(1);
        frame_done = n_wp == {1'b0, bfm_pkg::CRC_POS};
    end

    // a load writes the bank the active frame does not use for that entry
    always_comb begin
        ram_wr.en   = load_acc;
        ram_wr.addr = {~r_act_bank[r_wp], r_wp};
        ram_wr.data = i_item.payload_byte;
        ram_rd.en   = tick_acc && av_now && !is_sync && !is_crc;
        ram_rd.addr = {act_bank_now[byte_idx], byte_idx};
    end

    bfm_frame_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd      (ram_rd),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_bank  <= '0;
            r_sh_bank   <= '0;
            r_wp        <= '0;
            r_crc       <= bfm_pkg::CRC_INIT;
            r_swap_pend <= 1'b0;
            r_act_valid <= 1'b0;
            r_bit_pos   <= '0;
            r_smp_cnt   <= '0;
        end else if (load_acc) begin
            r_sh_bank[r_wp] <= ~r_act_bank[r_wp];
            if (frame_done) begin
                r_sh_crc    <= n_crc;
                r_swap_pend <= 1'b1;
                r_wp        <= '0;
                r_crc       <= bfm_pkg::CRC_INIT;
            end else begin
                r_wp  <= n_wp[bfm_pkg::IDX_W-1:0];
                r_crc <= n_crc;
            end
        end else if (tick_acc) begin
            if (swap) begin
                r_act_bank  <= r_sh_bank;
                r_act_crc   <= r_sh_crc;
                r_swap_pend <= 1'b0;
                r_act_valid <= 1'b1;
            end
            if (av_now) begin
                if (bit_done) begin
                    r_smp_cnt <= '0;
                    r_bit_pos <= (r_bit_pos == bfm_pkg::LAST_BIT) ? '0
                                 : r_bit_pos + bfm_pkg::BIT_W'(1);
                end else begin
                    r_smp_cnt <= n_smp_cnt[bfm_pkg::SPS_W-1:0];
                end
            end
        end
    end

    // read stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (tick_acc) begin
            r_s1_v <= 1'b1;
        end else if (s1_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_s1_av       <= av_now;
            r_s1_start    <= start;
            r_s1_sync     <= is_sync;
            r_s1_sync_bit <= r_sync[~r_bit_pos[4:0]];
            r_s1_crc      <= is_crc;
            r_s1_crc_byte <= act_crc_now;
            r_s1_bsel     <= r_bit_pos[2:0];
            r_s1_amp      <= r_amp;
        end
    end

    always_comb begin
        if (r_s1_sync) begin
            s1_bit = r_s1_sync_bit;
        end else if (r_s1_crc) begin
            s1_bit = r_s1_crc_byte[~r_s1_bsel];
        end else begin
            s1_bit = rd_data[~r_s1_bsel];
        end
        s1_pos = signed'({1'b0, r_s1_amp});
        if (!r_s1_av) begin
            s1_smp = '0;
        end else if (s1_bit) begin
            s1_smp = s1_pos;
        end else begin
            s1_smp = -s1_pos;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_adv) begin
            r_out_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_v) begin
            r_out_i  <= s1_smp;
            r_out_fs <= r_s1_av && r_s1_start;
            r_out_fv <= r_s1_av;
        end
    end

    assign o_sample.valid       = r_out_v;
    assign o_sample.i_sample    = r_out_i;
    assign o_sample.q_sample    = '0;
    assign o_sample.frame_start = r_out_fs;
    assign o_sample.frame_valid = r_out_fv;

    // a boundary tick with a pending frame always completes the swap
    a_swap_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc && start && r_swap_pend |=> !r_swap_pend && r_act_valid)
        else $error("pending frame not swapped at boundary");

    // counters stay parked until a frame is active
    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_act_valid |-> (r_bit_pos == '0) && (r_smp_cnt == '0))
        else $error("bit counters moved without an active frame");

    // the write position never reaches the crc slot
    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp != bfm_pkg::CRC_POS)
        else $error("write position reached crc slot");

    // frame start only on a sample of a live frame
    a_fs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_fs |-> r_out_fv)
        else $error("frame start without frame valid");

endmodule

// ===== tb/bpsk_frame_modulator_test.sv =====
// self-checking testbench for bpsk_frame_modulator: random item/tick traffic with
// random idling on both channels, checked against a frame/crc predictor
// depends on bfm_pkg, bfm_ifs and the rtl top level
module bpsk_frame_modulator_test;

    localparam int unsigned CLK_HALF    = 5;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_WAIT  = 8;
    localparam int unsigned MAX_REPORTS = 10;
    // index that maps to no register
    localparam logic [bfm_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef struct packed {
        logic [bfm_pkg::SMP_W-1:0] i_smp;
        logic [bfm_pkg::SMP_W-1:0] q_smp;
        logic                      start;
        logic                      valid;
    } t_sample;

    class frame_scoreboard;
        logic [bfm_pkg::SYNC_W-1:0] sync_pat;
        logic [bfm_pkg::AMP_W-1:0]  amplitude;
        logic [bfm_pkg::SPS_W-1:0]  sps;
        logic [7:0]        shadow [bfm_pkg::PAYLOAD_BYTES];
        logic [7:0]        active [bfm_pkg::PAYLOAD_BYTES];
        int unsigned       wr_pos;
        logic [7:0]        crc;
        bit                swap_pending;
        bit                active_valid;
        int unsigned       bit_pos;
        int unsigned       smp_cnt;
        t_sample           expected_q [$];
        int unsigned       mismatches;

        function new();
            sync_pat     = bfm_pkg::SYNC_RST;
            amplitude    = bfm_pkg::AMP_RST;
            sps          = bfm_pkg::SPS_RST;
            wr_pos       = 0;
            crc          = 8'h00;
            swap_pending = 0;
            active_valid = 0;
            bit_pos      = 0;
            smp_cnt      = 0;
            mismatches   = 0;
            for (int k = 0; k < bfm_pkg::PAYLOAD_BYTES; k++) begin
                shadow[k] = 8'h00;
                active[k] = 8'h00;
            end
        endfunction

        function void write_reg(logic [bfm_pkg::CFG_IDX_W-1:0] idx,
                                logic [bfm_pkg::CFG_DATA_W-1:0] d);
            unique case (idx)
                bfm_pkg::REG_SYNC:        sync_pat  = d[bfm_pkg::SYNC_W-1:0];
                bfm_pkg::REG_AMPLITUDE:   amplitude = d[bfm_pkg::AMP_W-1:0];
                bfm_pkg::REG_SAMPLES_SYM: sps       = d[bfm_pkg::SPS_W-1:0];
                default: ;
            endcase
        endfunction

        // crc-8 poly 0x07, msb first
        function logic [7:0] crc_update(logic [7:0] c, logic [7:0] b);
            logic [7:0] r;
            r = c ^ b;
            for (int k = 0; k < 8; k++) begin
                r = r[7] ? ({r[6:0], 1'b0} ^ 8'h07) : {r[6:0], 1'b0};
            end
            return r;
        endfunction

        function logic frame_bit_at(int unsigned pos);
            int unsigned off;
            if (pos < bfm_pkg::SYNC_BITS) return sync_pat[31 - pos];
            off = pos - bfm_pkg::SYNC_BITS;
            if ((off >> 3) >= bfm_pkg::PAYLOAD_BYTES) return 1'b0;
            return active[off >> 3][7 - (off & 7)];
        endfunction

        function void note_item(bfm_pkg::t_req_type req, logic [7:0] b);
            t_sample     s;
            bit          start;
            int unsigned eff_sps;
            logic [bfm_pkg::SMP_W-1:0] mag;
            if (req == bfm_pkg::REQ_LOAD) begin
                if (wr_pos >= bfm_pkg::PAYLOAD_BYTES - 1) wr_pos = 0;
                shadow[wr_pos] = b;
                crc = crc_update(crc, b);
                wr_pos++;
                if (wr_pos >= bfm_pkg::PAYLOAD_BYTES - 1) begin
                    shadow[bfm_pkg::PAYLOAD_BYTES - 1] = crc;
                    swap_pending = 1;
                    wr_pos = 0;
                    crc = 8'h00;
                end
                return;
            end
            start = (bit_pos == 0 && smp_cnt == 0);
            if (start && swap_pending) begin
                active = shadow;
                swap_pending = 0;
                active_valid = 1;
            end
            if (!active_valid) begin
                s = '0;
                expected_q.push_back(s);
                return;
            end
            mag     = {1'b0, amplitude};
            s.i_smp = frame_bit_at(bit_pos) ? mag : -mag;
            s.q_smp = '0;
            s.start = start;
            s.valid = 1'b1;
            expected_q.push_back(s);
            eff_sps = (sps == 0) ? 1 : sps;
            smp_cnt++;
            if (smp_cnt >= eff_sps) begin
                smp_cnt = 0;
                bit_pos++;
                if (bit_pos >= bfm_pkg::FRAME_BITS) bit_pos = 0;
            end
        endfunction

        function void check_sample(t_sample got);
            t_sample want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected sample: i=%0d q=%0d start=%0b valid=%0b",
                             $signed(got.i_smp), $signed(got.q_smp), got.start, got.valid);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"sample mismatch: exp i=%0d q=%0d start=%0b valid=%0b,",
                              " got i=%0d q=%0d start=%0b valid=%0b"},
                             $signed(want.i_smp), $signed(want.q_smp), want.start,
                             want.valid, $signed(got.i_smp), $signed(got.q_smp),
                             got.start, got.valid);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    bfm_item_if   item_ch ();
    bfm_cfg_if    cfg_ch ();
    bfm_sample_if smp_ch ();

    bpsk_frame_modulator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_sample (smp_ch)
    );

    frame_scoreboard sb;
    bit              no_idle    = 1'b0;
    bit              hold_req   = 1'b0;
    bit              hold_taken = 1'b0;
    int unsigned     cycles     = 0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic send_item(bfm_pkg::t_req_type req, logic [7:0] b);
        int unsigned gap;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.req_type     <= req;
        item_ch.payload_byte <= b;
        do @(posedge i_clk); while (!item_ch.ready);
        sb.note_item(req, b);
    endtask

    task automatic stop_items();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
    endtask

    // wait for every expected sample, then let in-flight loads settle
    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [bfm_pkg::CFG_IDX_W-1:0] idx,
                             logic [bfm_pkg::CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, d);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_traffic(int unsigned n_items, int unsigned load_pct,
                               int unsigned hold_at);
        bfm_pkg::t_req_type req;
        logic [7:0]         b;
        for (int unsigned n = 0; n < n_items; n++) begin
            if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (n == hold_at) hold_req = 1;
            req = ($urandom_range(0, 99) < load_pct) ? bfm_pkg::REQ_LOAD : bfm_pkg::REQ_TICK;
            case ($urandom_range(0, 9))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_item(req, b);
        end
    endtask

    // sample receiver with random stalls and one long hold-off on request
    initial begin
        int unsigned stall;
        t_sample     got;
        smp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req && !hold_taken) begin
                stall = HOLD_CYCLES;
                hold_taken = 1'b1;
            end else begin
                stall = draw_gap();
            end
            @(negedge i_clk);
            if (stall > 0) begin
                smp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            smp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!smp_ch.valid);
            got.i_smp = smp_ch.i_sample;
            got.q_smp = smp_ch.q_sample;
            got.start = smp_ch.frame_start;
            got.valid = smp_ch.frame_valid;
            sb.check_sample(got);
        end
    end

    initial begin
        logic [7:0] edge_bytes [7];
        edge_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hAA, 8'h55};
        sb       = new();
        i_rst_n  = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.req_type     = bfm_pkg::REQ_LOAD;
        item_ch.payload_byte = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = bfm_pkg::REG_SYNC;
        cfg_ch.data  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no frame loaded yet: ticks give all-zero samples
        repeat (4) send_item(bfm_pkg::REQ_TICK, 8'hFF);
        foreach (edge_bytes[k]) send_item(bfm_pkg::REQ_LOAD, edge_bytes[k]);
        repeat (3) send_item(bfm_pkg::REQ_TICK, 8'h00);
        for (int k = 0; k < 6; k++) begin
            send_item(bfm_pkg::REQ_LOAD, edge_bytes[k]);
            send_item(bfm_pkg::REQ_TICK, edge_bytes[6 - k]);
        end
        stop_items();
        wait_idle();

        // one sample per bit so frames wrap; long receiver hold-off in here
        write_reg(bfm_pkg::REG_SYNC, 32'hFFFF_FFFF);
        write_reg(bfm_pkg::REG_AMPLITUDE, 32'd32767);
        write_reg(bfm_pkg::REG_SAMPLES_SYM, 32'd1);
        run_traffic(250, 30, 120);
        run_traffic(550, 8, 1000);
        stop_items();
        wait_idle();

        // slowest bit rate, zero amplitude, zero sync word
        write_reg(bfm_pkg::REG_SYNC, 32'h0000_0000);
        write_reg(bfm_pkg::REG_AMPLITUDE, 32'd0);
        write_reg(bfm_pkg::REG_SAMPLES_SYM, 32'd15);
        run_traffic(300, 40, 1000);
        stop_items();
        wait_idle();

        // zero samples per symbol acts as one; write to the unused index too
        write_reg(bfm_pkg::REG_SYNC, $urandom);
        write_reg(bfm_pkg::REG_AMPLITUDE, 32'd1);
        write_reg(bfm_pkg::REG_SAMPLES_SYM, 32'd0);
        write_reg(REG_NONE, $urandom);
        run_traffic(300, 20, 1000);
        stop_items();
        wait_idle();

        write_reg(bfm_pkg::REG_SYNC, $urandom);
        write_reg(bfm_pkg::REG_AMPLITUDE, 32'($urandom_range(0, 32767)));
        write_reg(bfm_pkg::REG_SAMPLES_SYM, 32'($urandom_range(1, 15)));
        run_traffic(200, 20, 1000);
        stop_items();
        wait_idle();

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== bpsk_frame_modulator.f =====
rtl/bfm_pkg.sv
rtl/bfm_ifs.sv
rtl/bfm_frame_ram.sv
rtl/bpsk_frame_modulator.sv
tb/bpsk_frame_modulator_test.sv
